// ----- rtl/rdq_pkg.sv -----
// Shared types and codes for the reversible deque buffer.
package rdq_pkg;

    typedef enum logic [2:0] {
        ACT_CLEAR   = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_REVERSE = 3'd2,
        ACT_DELETE  = 3'd3,
        ACT_FINISH  = 3'd4
    } action_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } drain_state_t;

    // Per-cycle read control from the drain sequencer.
    typedef struct packed {
        logic rd_en;
        logic last;
    } drain_ctl_t;

endpackage

// ----- rtl/rdq_drain.sv -----
// Drain sequencer: walks the ring storage in logical order, one read per cycle.
module rdq_drain #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [$clog2(DEPTH)-1:0]      head,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic                          reversed,
    output logic                          busy,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    output rdq_pkg::drain_ctl_t           ctl
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rdq_pkg::drain_state_t state_reg, state_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [CW-1:0]         remaining_reg, remaining_next;
    logic [CW:0]           tail_sum;
    logic [AW-1:0]         tail_idx;
    logic [AW-1:0]         ptr_step;

    // physical index of the last element: head + count - 1, wrapped once
    always_comb
    begin
        tail_sum = (CW+1)'(head) + (CW+1)'(count) - (CW+1)'(1);
        if (tail_sum >= (CW+1)'(DEPTH))
        begin
            tail_sum = tail_sum - (CW+1)'(DEPTH);
        end
        tail_idx = tail_sum[AW-1:0];
    end

    always_comb
    begin
        if (reversed)
        begin
            ptr_step = (ptr_reg == '0) ? AW'(DEPTH - 1) : ptr_reg - AW'(1);
        end
        else
        begin
            ptr_step = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + AW'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdq_pkg::ST_IDLE:
            begin
                if (go)
                begin
                    state_next = rdq_pkg::ST_DRAIN;
                end
            end
            rdq_pkg::ST_DRAIN:
            begin
                if (remaining_reg == CW'(1))
                begin
                    state_next = rdq_pkg::ST_IDLE;
                end
            end
            default: state_next = rdq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = 1'b0;
        ctl.rd_en = 1'b0;
        ctl.last  = 1'b0;
        case (state_reg)
            rdq_pkg::ST_DRAIN:
            begin
                busy      = 1'b1;
                ctl.rd_en = 1'b1;
                ctl.last  = (remaining_reg == CW'(1));
            end
            default:
            begin
                busy      = 1'b0;
                ctl.rd_en = 1'b0;
                ctl.last  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ptr_next       = ptr_reg;
        remaining_next = remaining_reg;
        if (go)
        begin
            ptr_next       = reversed ? tail_idx : head;
            remaining_next = count;
        end
        else if (state_reg == rdq_pkg::ST_DRAIN)
        begin
            ptr_next       = ptr_step;
            remaining_next = remaining_reg - CW'(1);
        end
    end

    assign rd_addr = ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdq_pkg::ST_IDLE;
            ptr_reg       <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ----- rtl/reversible_deque_buffer_core.sv -----
// Reversible deque buffer: ring storage in a synchronous RAM with a direction flag.
//
// Usage
//   Commands enter on start/action/value and are taken at a clock edge where
//   start is high and busy is low. One command per cycle is accepted while idle.
//   clear, append, reverse and delete update pointers and flags at the edge that
//   takes them and give no result.
//   finish gives results on element/is_error/is_empty/overflowed/last, each
//   valid for exactly one cycle while strobe is high; last marks the final one.
//   Results: an error or empty-list result shows in the cycle after the finish
//   transaction. A list streams out through the drain pointer register, then the
//   RAM read register with the result flags, one element per cycle; busy stays
//   high while the elements are read and drops in the cycle that shows the final element.
//   Throughput: one command per cycle while idle; a finish of a non-empty list
//   holds busy while it drains, and the next command is taken once busy drops.
//   The single read port of the storage RAM sets this.
//   Reset clears head, count and all flags; the RAM contents are not cleared
//   and need no clearing pass since only written entries are ever read.
//   The receiver cannot stall: results are shown once and not held.
module reversible_deque_buffer_core #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [15:0] value,
    output logic        strobe,
    output logic [15:0] element,
    output logic        is_error,
    output logic        is_empty,
    output logic        overflowed,
    output logic        last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // list state
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          err_reg, err_next;
    logic          ovf_reg, ovf_next;

    // result register
    logic          res_strobe_reg, res_strobe_next;
    logic          res_err_reg, res_err_next;
    logic          res_empty_reg, res_empty_next;
    logic          res_last_reg, res_last_next;
    logic          res_mem_reg, res_mem_next;

    // storage RAM
    logic [15:0]   mem [DEPTH];
    logic [15:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW:0]   wr_sum;
    logic [AW-1:0] rd_addr;

    logic                accept;
    logic                go;
    logic                drain_busy;
    rdq_pkg::drain_ctl_t ctl;
    rdq_pkg::action_t    act;

    assign act    = rdq_pkg::action_t'(action);
    assign accept = start && !drain_busy;
    assign busy   = drain_busy;

    // physical back: head + count, wrapped once
    always_comb
    begin
        wr_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (wr_sum >= (CW+1)'(DEPTH))
        begin
            wr_sum = wr_sum - (CW+1)'(DEPTH);
        end
        wr_addr = wr_sum[AW-1:0];
    end

    // command decode
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        err_next        = err_reg;
        ovf_next        = ovf_reg;
        wr_en           = 1'b0;
        go              = 1'b0;
        res_strobe_next = ctl.rd_en;
        res_err_next    = 1'b0;
        res_empty_next  = 1'b0;
        res_last_next   = ctl.last;
        res_mem_next    = ctl.rd_en;
        if (accept)
        begin
            case (act)
                rdq_pkg::ACT_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                    rev_next   = 1'b0;
                    err_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
                rdq_pkg::ACT_APPEND:
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                rdq_pkg::ACT_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                rdq_pkg::ACT_DELETE:
                begin
                    if (!err_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (!rev_reg)
                            begin
                                head_next = (head_reg == AW'(DEPTH - 1)) ?
                                            '0 : head_reg + AW'(1);
                            end
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                rdq_pkg::ACT_FINISH:
                begin
                    if (err_reg)
                    begin
                        res_strobe_next = 1'b1;
                        res_err_next    = 1'b1;
                        res_last_next   = 1'b1;
                        res_mem_next    = 1'b0;
                    end
                    else if (count_reg == '0)
                    begin
                        res_strobe_next = 1'b1;
                        res_empty_next  = 1'b1;
                        res_last_next   = 1'b1;
                        res_mem_next    = 1'b0;
                    end
                    else
                    begin
                        go = 1'b1;
                    end
                end
                default:
                begin
                    // unused codes: no effect
                    go = 1'b0;
                end
            endcase
        end
    end

    rdq_drain #(
        .DEPTH (DEPTH)
    ) u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .head     (head_reg),
        .count    (count_reg),
        .reversed (rev_reg),
        .busy     (drain_busy),
        .rd_addr  (rd_addr),
        .ctl      (ctl)
    );

    // RAM: one write port for appends, one registered read port for drains.
    // Writes happen only while idle and reads only while busy, so the two
    // never touch the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            rev_reg        <= 1'b0;
            err_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            res_strobe_reg <= 1'b0;
            res_err_reg    <= 1'b0;
            res_empty_reg  <= 1'b0;
            res_last_reg   <= 1'b0;
            res_mem_reg    <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            rev_reg        <= rev_next;
            err_reg        <= err_next;
            ovf_reg        <= ovf_next;
            res_strobe_reg <= res_strobe_next;
            res_err_reg    <= res_err_next;
            res_empty_reg  <= res_empty_next;
            res_last_reg   <= res_last_next;
            res_mem_reg    <= res_mem_next;
        end
    end

    // overflow flag cannot change between a finish and its results
    assign strobe     = res_strobe_reg;
    assign element    = res_mem_reg ? rd_data_reg : '0;
    assign is_error   = res_err_reg;
    assign is_empty   = res_empty_reg;
    assign overflowed = ovf_reg;
    assign last       = res_last_reg;

    // the final result of a finish always comes with the block free again
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy still high on final result");

    // a command other than finish never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (act != rdq_pkg::ACT_FINISH) |=> !strobe)
        else $error("result without finish");

    // finish after a failed delete gives exactly one error result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (act == rdq_pkg::ACT_FINISH) && err_reg
        |=> strobe && is_error && last && !busy)
        else $error("missing error result");

    // fill level stays within storage
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

endmodule

// ----- bench/reversible_deque_buffer_core_test.sv -----
// Self-checking deque buffer bench: directed table, capacity run, then random sessions.
`timescale 1ns / 100ps

module reversible_deque_buffer_core_test;

    localparam int RING_DEPTH = 64;
    // Action codes the block does not decode; they must be ignored.
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam int ITEM_TARGET = 310;
    localparam int REPORT_LIMIT = 10;
    localparam int TAIL_CYCLES = 8;

    // One emitted result, laid out as the output ports.
    typedef struct packed {
        logic [15:0] element;
        logic        is_error;
        logic        is_empty;
        logic        overflowed;
        logic        last;
    } emit_t;

    // One directed command; 'typed' rows carry their single result written out by hand.
    typedef struct packed {
        logic [2:0]  act;
        logic [15:0] val;
        logic        typed;
        emit_t       emit;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [15:0] value;
    logic        strobe;
    logic [15:0] element;
    logic        is_error;
    logic        is_empty;
    logic        overflowed;
    logic        last;

    // Shadow deque: ring contents, pointers and the three flags.
    logic [15:0] ring [RING_DEPTH];
    logic [5:0]  head;
    logic [6:0]  fill;
    logic        rev_flag;
    logic        err_flag;
    logic        ovf_flag;

    emit_t       drain_due [$];     // results still owed by the block, oldest first
    cmd_row_t    directed_rows [$];
    int          mismatches = 0;
    int          items_sent = 0;    // decoded commands only
    bit          burst;             // no idle cycles between commands while set

    reversible_deque_buffer_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .strobe    (strobe),
        .element   (element),
        .is_error  (is_error),
        .is_empty  (is_empty),
        .overflowed(overflowed),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic emit_t mk_emit(input logic [15:0] el, input logic err,
                                      input logic emp, input logic ovf, input logic lst);
        emit_t e;
        e.element    = el;
        e.is_error   = err;
        e.is_empty   = emp;
        e.overflowed = ovf;
        e.last       = lst;
        return e;
    endfunction

    function automatic logic [15:0] rand16();
        logic [15:0] v;
        v = 16'($urandom);
        return v;
    endfunction

    // Append a result to the owed list.
    task automatic owe_result(input emit_t e);
        drain_due.insert(drain_due.size(), e);
    endtask

    // Advance the shadow deque by one command. A finish queues its results when
    // emit_on is set; finish itself never changes state.
    task automatic deque_update(input logic [2:0] act, input logic [15:0] val,
                                input bit emit_on);
        int k;
        int off;
        case (act)
            rdq_pkg::ACT_CLEAR:
            begin
                head     = '0;
                fill     = '0;
                rev_flag = 1'b0;
                err_flag = 1'b0;
                ovf_flag = 1'b0;
            end
            rdq_pkg::ACT_APPEND:
            begin
                // goes to the physical back even when reversed or in error
                if (fill < RING_DEPTH)
                begin
                    ring[6'((head + fill) % RING_DEPTH)] = val;
                    fill = fill + 1'b1;
                end
                else
                    ovf_flag = 1'b1;
            end
            rdq_pkg::ACT_REVERSE:
                rev_flag = ~rev_flag;
            rdq_pkg::ACT_DELETE:
            begin
                if (!err_flag)
                begin
                    if (fill == 0)
                        err_flag = 1'b1;
                    else
                    begin
                        // reversed: logical front is the physical back, head stays
                        if (!rev_flag)
                            head = 6'((head + 1) % RING_DEPTH);
                        fill = fill - 1'b1;
                    end
                end
            end
            rdq_pkg::ACT_FINISH:
            begin
                if (emit_on)
                begin
                    if (err_flag)
                        owe_result(mk_emit('0, 1'b1, 1'b0, ovf_flag, 1'b1));
                    else if (fill == 0)
                        owe_result(mk_emit('0, 1'b0, 1'b1, ovf_flag, 1'b1));
                    else
                        for (k = 0; k < fill; k++)
                        begin
                            off = rev_flag ? fill - 1 - k : k;
                            owe_result(mk_emit(ring[6'((head + off) % RING_DEPTH)],
                                               1'b0, 1'b0, ovf_flag, k + 1 == fill));
                        end
                end
            end
            default:
                ;
        endcase
    endtask

    // Present one command and hold it until the block takes it. Only one
    // nonblocking write per signal per step: start is lowered only when an
    // idle gap is drawn, otherwise it stays high into the next transaction.
    task automatic issue(input logic [2:0] act, input logic [15:0] val,
                         input logic typed, input emit_t typed_emit);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        // busy is read before this edge's updates land, so !busy here means taken
        do
            @(posedge clk);
        while (busy);
        deque_update(act, val, !typed);
        if (typed)
            owe_result(typed_emit);
        if (act <= rdq_pkg::ACT_FINISH)
            items_sent++;
    endtask

    task automatic send(input logic [2:0] act, input logic [15:0] val);
        issue(act, val, 1'b0, '0);
    endtask

    task automatic add_row(input logic [2:0] act, input logic [15:0] val,
                           input logic typed, input emit_t emit);
        cmd_row_t r;
        r.act   = act;
        r.val   = val;
        r.typed = typed;
        r.emit  = emit;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Hold off the sender until every owed result has come out.
    task automatic settle();
        start <= 1'b0;
        while (drain_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly appends, so lists grow and finishes stream real contents.
    // Deletes on an empty list are thinned out so the error state stays occasional.
    function automatic logic [2:0] pick_action();
        int unsigned r;
        logic [2:0] code;
        r = $urandom_range(0, 99);
        if (r < 50)
            code = rdq_pkg::ACT_APPEND;
        else if (r < 66)
            code = (fill == 0 && r < 62) ? rdq_pkg::ACT_APPEND : rdq_pkg::ACT_DELETE;
        else if (r < 76)
            code = rdq_pkg::ACT_REVERSE;
        else if (r < 90)
            code = rdq_pkg::ACT_FINISH;
        else if (r < 95)
            code = rdq_pkg::ACT_CLEAR;
        else
            code = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        return code;
    endfunction

    // A well-formed session: clear, random body, closing finish.
    task automatic session(input int ops);
        send(rdq_pkg::ACT_CLEAR, rand16());
        repeat (ops) send(pick_action(), rand16());
        send(rdq_pkg::ACT_FINISH, rand16());
    endtask

    task automatic report_miss(input string why, input emit_t want, input emit_t seen);
        if (mismatches < REPORT_LIMIT)
            $display("%0t %s: want el=%h err=%b emp=%b ovf=%b last=%b, %s",
                     $time, why,
                     want.element, want.is_error, want.is_empty, want.overflowed, want.last,
                     $sformatf("got el=%h err=%b emp=%b ovf=%b last=%b",
                               seen.element, seen.is_error, seen.is_empty,
                               seen.overflowed, seen.last));
        mismatches++;
    endtask

    // Result checker: a result counts in the cycle strobe is high and is
    // taken at the edge closing it; compare against the oldest owed result.
    always @(posedge clk)
    begin : check_emit
        emit_t seen;
        emit_t want;
        if (rst_n && strobe)
        begin
            seen = mk_emit(element, is_error, is_empty, overflowed, last);
            if (drain_due.size() == 0)
                report_miss("result with nothing owed", '0, seen);
            else
            begin
                want = drain_due[0];
                drain_due.delete(0);
                if (seen !== want)
                    report_miss("result mismatch", want, seen);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int s;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        action <= rdq_pkg::ACT_CLEAR;
        value  <= '0;
        burst  = 1'b0;
        head     = '0;
        fill     = '0;
        rev_flag = 1'b0;
        err_flag = 1'b0;
        ovf_flag = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Hand-written results only where obvious; the rest
        // are worked out by the shadow deque.
        // finish straight after reset: empty-list marker
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b1,
                mk_emit(16'h0000, 1'b0, 1'b1, 1'b0, 1'b1));
        // delete on empty sets error; the second delete is ignored
        add_row(rdq_pkg::ACT_DELETE,  16'hFFFF, 1'b0, '0);
        add_row(rdq_pkg::ACT_DELETE,  16'h0000, 1'b0, '0);
        // append after error still stores, but finish reports only the error
        add_row(rdq_pkg::ACT_APPEND,  16'hFFFF, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'hFFFF, 1'b1,
                mk_emit(16'h0000, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(rdq_pkg::ACT_CLEAR,   16'hFFFF, 1'b0, '0);
        add_row(rdq_pkg::ACT_APPEND,  16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_APPEND,  16'hFFFF, 1'b0, '0);
        add_row(rdq_pkg::ACT_APPEND,  16'h5A5A, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_REVERSE, 16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b0, '0);
        // reversed delete drops the physical back; reversed append still goes there
        add_row(rdq_pkg::ACT_DELETE,  16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_APPEND,  16'h1234, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b0, '0);
        add_row(ACT_UNUSED_LO, 16'hFFFF, 1'b0, '0);
        add_row(ACT_UNUSED_HI, 16'hFFFF, 1'b0, '0);
        add_row(rdq_pkg::ACT_REVERSE, 16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_DELETE,  16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_CLEAR,   16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_APPEND,  16'hA5A5, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b1,
                mk_emit(16'hA5A5, 1'b0, 1'b0, 1'b0, 1'b1));
        add_row(rdq_pkg::ACT_REVERSE, 16'h0000, 1'b0, '0);
        add_row(rdq_pkg::ACT_FINISH,  16'h0000, 1'b1,
                mk_emit(16'hA5A5, 1'b0, 1'b0, 1'b0, 1'b1));
        foreach (directed_rows[i])
            issue(directed_rows[i].act, directed_rows[i].val,
                  directed_rows[i].typed, directed_rows[i].emit);
        settle();

        // Capacity: fill past full (drops set overflow), then free the front
        // and refill so the ring wraps, read both ways, and drop once more.
        send(rdq_pkg::ACT_CLEAR, rand16());
        repeat (RING_DEPTH + 3) send(rdq_pkg::ACT_APPEND, rand16());
        send(rdq_pkg::ACT_FINISH, rand16());
        repeat (10) send(rdq_pkg::ACT_DELETE, rand16());
        repeat (10) send(rdq_pkg::ACT_APPEND, rand16());
        send(rdq_pkg::ACT_FINISH, rand16());
        send(rdq_pkg::ACT_REVERSE, rand16());
        send(rdq_pkg::ACT_APPEND, rand16());
        repeat (5) send(rdq_pkg::ACT_DELETE, rand16());
        send(rdq_pkg::ACT_FINISH, rand16());
        settle();

        // Random sessions, some back to back, with a full drain every few.
        s = 0;
        while (items_sent < ITEM_TARGET)
        begin
            burst = ($urandom_range(0, 3) == 0);
            session($urandom_range(4, 18));
            s++;
            if (s % 4 == 0)
                settle();
        end
        burst = 1'b0;

        start <= 1'b0;
        while (drain_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && drain_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
